@@ hw/rtl/bmh_pkg.sv @@
// Shared types and codes for the binary max-heap priority queue.
`timescale 1ns / 1ps
package bmh_pkg;
	localparam logic [1:0] MODE_INSERT  = 2'd0;
	localparam logic [1:0] MODE_EXTRACT = 2'd1;
	localparam logic [1:0] MODE_REMOVE  = 2'd2;
	localparam logic [1:0] MODE_QUERY   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_BAD_POS  = 2'd3;

	localparam int KEY_FIELD_BITS = 32;
	localparam int PAY_FIELD_BITS = 32;
	localparam int POS_FIELD_BITS = 6;
	localparam int CNT_FIELD_BITS = 7;

	typedef struct packed {
		logic [1:0]                  mode;
		logic signed [KEY_FIELD_BITS-1:0] key;
		logic [PAY_FIELD_BITS-1:0]   payload;
		logic [POS_FIELD_BITS-1:0]   position;
	} cmd_t;

	typedef struct packed {
		logic signed [KEY_FIELD_BITS-1:0] taken_key;
		logic [PAY_FIELD_BITS-1:0]   taken_payload;
		logic signed [KEY_FIELD_BITS-1:0] top_key;
		logic [PAY_FIELD_BITS-1:0]   top_payload;
		logic [CNT_FIELD_BITS-1:0]   count;
		logic                        is_empty;
		logic [1:0]                  status;
	} res_t;
endpackage

@@ hw/rtl/bmh_if.sv @@
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
interface bmh_cmd_if;
	import bmh_pkg::*;
	logic valid;
	logic ready;
	cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bmh_res_if;
	import bmh_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/binary_max_heap_priority_queue.sv @@
// Top level of the binary max-heap priority queue.
//  channel | dir | payload
//  cmd     | in  | mode, key, payload, position
//  res     | out | taken_key, taken_payload, top_key, top_payload, count, is_empty, status
// Query and rejected commands walk no levels; insert climbs levels, while extract and remove
// may move down and then up, bounded by the single read port of the entry RAM.
// Reset clears the entry count; the RAM holds no reset state.
// A two-entry queue takes commands while the engine or a stalled result is busy.
`timescale 1ns / 1ps
module binary_max_heap_priority_queue #(
	parameter int CAPACITY     = 64,
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 32
) (
	input logic      clk,
	input logic      arst_n,
	bmh_cmd_if.sink  cmd,
	bmh_res_if.source res
);
	import bmh_pkg::*;

	logic q_valid, q_pop;
	cmd_t q_data;

	bmh_front u_front (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
	);

	bmh_back #(
		.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_data(q_data),
		.q_pop(q_pop), .res(res)
	);
endmodule

@@ hw/rtl/bmh_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module bmh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hw/rtl/bmh_front.sv @@
// Command front end: accepts commands and holds them in a two-entry queue.
`timescale 1ns / 1ps
module bmh_front (
	input  logic           clk,
	input  logic           arst_n,
	bmh_cmd_if.sink        cmd,
	output logic           q_valid,
	output bmh_pkg::cmd_t  q_data,
	input  logic           q_pop
);
	import bmh_pkg::*;

	cmd_t       slot_q [2];
	logic       rd_q, wr_q;
	logic [1:0] fill_q;

	assign cmd.ready = (fill_q != 2'd2);
	assign q_valid   = (fill_q != 2'd0);
	assign q_data    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			slot_q[wr_q] <= cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= 1'b0;
			wr_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			fill_q <= fill_q + 2'(cmd.valid && cmd.ready) - 2'(q_pop);
		end
	end
endmodule

@@ hw/rtl/bmh_back.sv @@
// Heap engine: runs one command at a time with sift-up and sift-down walks.
`timescale 1ns / 1ps
module bmh_back #(
	parameter int CAPACITY     = 64,
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  bmh_pkg::cmd_t  q_data,
	output logic           q_pop,
	bmh_res_if.source      res
);
	import bmh_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = KEY_BITS + PAYLOAD_BITS;
	localparam int PW = (CW > POS_FIELD_BITS) ? CW : POS_FIELD_BITS;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_TAKE_RD = 4'd1;
	localparam logic [3:0] S_LAST_RD = 4'd2;
	localparam logic [3:0] S_LAST    = 4'd3;
	localparam logic [3:0] S_DN_RD   = 4'd4;
	localparam logic [3:0] S_DN_R2   = 4'd5;
	localparam logic [3:0] S_DN_CMP  = 4'd6;
	localparam logic [3:0] S_UP_RD   = 4'd7;
	localparam logic [3:0] S_UP_CMP  = 4'd8;
	localparam logic [3:0] S_TOP_RD  = 4'd9;
	localparam logic [3:0] S_TOP     = 4'd10;

	logic [3:0]     state_q;
	logic [CW-1:0]  cnt_q;
	logic [AW-1:0]  at_q;      // hole position of the walk
	logic [EW-1:0]  mov_q;     // entry being sifted
	logic [EW-1:0]  left_q;
	logic [1:0]     status_q;
	logic [EW-1:0]  taken_q;
	logic           taken_v_q;
	res_t           res_q;
	logic           res_v_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;

	bmh_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	function automatic logic gt(input logic [EW-1:0] a, input logic [EW-1:0] b);
		return $signed(a[EW-1 -: KEY_BITS]) > $signed(b[EW-1 -: KEY_BITS]);
	endfunction

	logic [CW:0]         lidx, ridx;
	logic [AW-1:0]       par;
	logic [PW-1:0]       cmd_pos;
	logic [KEY_BITS-1:0] in_key;
	logic                take_right;
	logic [EW-1:0]       pick_e;
	logic [AW-1:0]       pick_idx;
	logic                res_load;

	assign lidx = (CW+1)'({at_q, 1'b1});
	assign ridx = lidx + (CW+1)'(1);
	assign par  = (at_q - AW'(1)) >> 1;
	assign cmd_pos = (q_data.mode == MODE_EXTRACT) ? '0 : PW'(q_data.position);
	assign in_key  = KEY_BITS'($signed(q_data.key));

	// left wins when there is no right child or when strictly greater than it; ties go right
	assign take_right = (ridx < (CW+1)'(cnt_q)) && !gt(left_q, rdata);
	assign pick_e     = take_right ? rdata : left_q;
	assign pick_idx   = take_right ? AW'(ridx) : AW'(lidx);

	assign res_load  = (state_q == S_TOP) && (!res_v_q || res.ready);
	assign res.valid = res_v_q;
	assign res.data  = res_q;
	assign q_pop     = (state_q == S_IDLE) && q_valid;

	always_comb begin
		we = 1'b0;
		waddr = at_q;
		wdata = mov_q;
		raddr = at_q;
		case (state_q)
			S_LAST_RD: raddr = AW'(cnt_q);
			S_DN_RD:   raddr = AW'(lidx);
			S_DN_R2:   raddr = AW'(ridx);
			S_DN_CMP: begin
				// move the larger child into the hole when it beats the sifted entry
				we = gt(pick_e, mov_q);
				wdata = pick_e;
			end
			S_UP_RD: begin
				raddr = par;
				we = (at_q == '0);
			end
			S_UP_CMP: begin
				we = 1'b1;
				wdata = gt(mov_q, rdata) ? rdata : mov_q;
			end
			S_TOP_RD, S_TOP: raddr = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mov_q <= {in_key, PAYLOAD_BITS'(q_data.payload)};
				at_q  <= (q_data.mode == MODE_INSERT) ? AW'(cnt_q) : AW'(cmd_pos);
				taken_v_q <= 1'b0;
			end
			S_LAST_RD: begin
				taken_q   <= rdata;
				taken_v_q <= 1'b1;
			end
			S_LAST:   mov_q <= rdata;
			S_DN_R2:  left_q <= rdata;
			S_DN_CMP: if (gt(pick_e, mov_q)) at_q <= pick_idx;
			S_UP_CMP: if (gt(mov_q, rdata)) at_q <= par;
			S_TOP: if (res_load) begin
				res_q.taken_key     <= taken_v_q ?
					KEY_FIELD_BITS'($signed(taken_q[EW-1 -: KEY_BITS])) : '0;
				res_q.taken_payload <= taken_v_q ?
					PAY_FIELD_BITS'(taken_q[PAYLOAD_BITS-1:0]) : '0;
				res_q.top_key       <= (cnt_q != '0) ?
					KEY_FIELD_BITS'($signed(rdata[EW-1 -: KEY_BITS])) : '0;
				res_q.top_payload   <= (cnt_q != '0) ?
					PAY_FIELD_BITS'(rdata[PAYLOAD_BITS-1:0]) : '0;
				res_q.count         <= CNT_FIELD_BITS'(cnt_q);
				res_q.is_empty      <= (cnt_q == '0);
				res_q.status        <= status_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			status_q <= ST_OK;
			res_v_q  <= 1'b0;
		end else begin
			if (res_load) res_v_q <= 1'b1;
			else if (res.ready) res_v_q <= 1'b0;
			case (state_q)
				S_IDLE: if (q_valid) begin
					case (q_data.mode)
						MODE_INSERT: if (cnt_q >= CW'(CAPACITY)) begin
							status_q <= ST_FULL;
							state_q  <= S_TOP_RD;
						end else begin
							status_q <= ST_OK;
							cnt_q    <= cnt_q + CW'(1);
							state_q  <= S_UP_RD;
						end
						MODE_EXTRACT, MODE_REMOVE:
							if (q_data.mode == MODE_EXTRACT && cnt_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_TOP_RD;
							end else if (cmd_pos >= PW'(cnt_q)) begin
								status_q <= ST_BAD_POS;
								state_q  <= S_TOP_RD;
							end else begin
								status_q <= ST_OK;
								cnt_q    <= cnt_q - CW'(1);
								state_q  <= S_TAKE_RD;
							end
						default: begin
							status_q <= ST_OK;
							state_q  <= S_TOP_RD;
						end
					endcase
				end
				S_TAKE_RD: state_q <= S_LAST_RD;
				// drop the last slot outright, else refill the hole with the last entry
				S_LAST_RD: state_q <= (CW'(at_q) == cnt_q) ? S_TOP_RD : S_LAST;
				S_LAST:    state_q <= S_DN_RD;
				S_DN_RD:   state_q <= (lidx < (CW+1)'(cnt_q)) ? S_DN_R2 : S_UP_RD;
				S_DN_R2:   state_q <= S_DN_CMP;
				S_DN_CMP:  state_q <= gt(pick_e, mov_q) ? S_DN_RD : S_UP_RD;
				S_UP_RD:   state_q <= (at_q == '0) ? S_TOP_RD : S_UP_CMP;
				S_UP_CMP:  state_q <= gt(mov_q, rdata) ? S_UP_RD : S_TOP_RD;
				S_TOP_RD:  state_q <= S_TOP;
				S_TOP: if (res_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the binary max-heap priority queue.
`timescale 1ns / 1ps
module tb;
	import bmh_pkg::*;

	localparam int DEPTH      = 64;
	localparam int RAND_ITEMS = 1950;
	localparam int TAIL_ITEMS = 200;
	localparam int HOLD_CYCLES = 400;

	logic clk;
	logic arst_n;

	bmh_cmd_if cmd ();
	bmh_res_if res ();

	binary_max_heap_priority_queue uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.res(res)
	);

	// shadow heap
	logic signed [KEY_FIELD_BITS-1:0] heap_key [DEPTH];
	logic [PAY_FIELD_BITS-1:0] heap_pay [DEPTH];
	int heap_cnt;

	cmd_t pending_cmds [$];
	res_t expected_res [$];
	int total_cmds;
	int sent_cmds;
	int checked_res;
	int mismatches;
	int cmd_gap;
	int res_gap;
	logic hold_off;
	int status_seen [4];
	int max_fill;

	function automatic bit key_above(int a, int b);
		return heap_key[a] > heap_key[b];
	endfunction

	task automatic swap_entries(int a, int b);
		logic signed [KEY_FIELD_BITS-1:0] k;
		logic [PAY_FIELD_BITS-1:0] p;
		k = heap_key[a];
		p = heap_pay[a];
		heap_key[a] = heap_key[b];
		heap_pay[a] = heap_pay[b];
		heap_key[b] = k;
		heap_pay[b] = p;
	endtask

	task automatic bubble_up(int at);
		int up;
		while (at > 0) begin
			up = (at - 1) / 2;
			if (!key_above(at, up))
				break;
			swap_entries(up, at);
			at = up;
		end
	endtask

	task automatic bubble_down(int at);
		int pick;
		while (2 * at + 1 < heap_cnt) begin
			pick = 2 * at + 1;
			if (pick + 1 < heap_cnt && !key_above(pick, pick + 1))
				pick = pick + 1;
			if (!key_above(pick, at))
				break;
			swap_entries(pick, at);
			at = pick;
		end
	endtask

	task automatic heap_apply(input cmd_t c, output res_t r);
		int slot;
		r = '0;
		r.status = ST_OK;
		case (c.mode)
			MODE_INSERT: begin
				if (heap_cnt >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					heap_key[heap_cnt] = c.key;
					heap_pay[heap_cnt] = c.payload;
					heap_cnt++;
					bubble_up(heap_cnt - 1);
				end
			end
			MODE_EXTRACT, MODE_REMOVE: begin
				slot = (c.mode == MODE_EXTRACT) ? 0 : int'(c.position);
				if (c.mode == MODE_EXTRACT && heap_cnt == 0) begin
					r.status = ST_EMPTY;
				end else if (slot >= heap_cnt) begin
					r.status = ST_BAD_POS;
				end else begin
					r.taken_key = heap_key[slot];
					r.taken_payload = heap_pay[slot];
					swap_entries(slot, heap_cnt - 1);
					heap_cnt--;
					if (slot < heap_cnt) begin
						bubble_down(slot);
						bubble_up(slot);
					end
				end
			end
			default: ;
		endcase
		if (heap_cnt > 0) begin
			r.top_key = heap_key[0];
			r.top_payload = heap_pay[0];
		end
		r.count = heap_cnt[CNT_FIELD_BITS-1:0];
		r.is_empty = (heap_cnt == 0);
	endtask

	task automatic queue_cmd(logic [1:0] mode, logic [31:0] key, logic [31:0] pay,
			logic [5:0] pos);
		cmd_t c;
		res_t r;
		c.mode = mode;
		c.key = key;
		c.payload = pay;
		c.position = pos;
		heap_apply(c, r);
		pending_cmds.push_back(c);
		expected_res.push_back(r);
		status_seen[r.status]++;
		if (heap_cnt > max_fill)
			max_fill = heap_cnt;
	endtask

	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff - $urandom_range(0, 3);
			1: return 32'h8000_0000 + $urandom_range(0, 3);
			2: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int fill_bias;
		logic [1:0] m;
		logic [5:0] p;
		heap_cnt = 0;
		max_fill = 0;
		// directed: empty misuse, key extremes, ties, remove cases
		queue_cmd(MODE_QUERY, 32'h0, 32'h0, 6'd0);
		queue_cmd(MODE_EXTRACT, 32'h0, 32'h0, 6'd0);
		queue_cmd(MODE_REMOVE, 32'h0, 32'h0, 6'd0);
		queue_cmd(MODE_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 6'd63);
		queue_cmd(MODE_INSERT, 32'h8000_0000, 32'h0000_0000, 6'd0);
		queue_cmd(MODE_INSERT, 32'h0, 32'h1234_5678, 6'd0);
		queue_cmd(MODE_INSERT, 32'hffff_ffff, 32'h8765_4321, 6'd0);
		queue_cmd(MODE_INSERT, 32'd5, 32'h0000_0a01, 6'd0);
		queue_cmd(MODE_INSERT, 32'd5, 32'h0000_0a02, 6'd0);
		queue_cmd(MODE_INSERT, 32'd5, 32'h0000_0a03, 6'd0);
		queue_cmd(MODE_QUERY, 32'hffff_ffff, 32'hffff_ffff, 6'd63);
		queue_cmd(MODE_REMOVE, 32'h0, 32'h0, 6'(heap_cnt - 1));
		queue_cmd(MODE_REMOVE, 32'h0, 32'h0, 6'd1);
		queue_cmd(MODE_REMOVE, 32'h0, 32'h0, 6'd63);
		queue_cmd(MODE_REMOVE, 32'h0, 32'h0, 6'(heap_cnt));
		queue_cmd(MODE_EXTRACT, 32'h0, 32'h0, 6'd0);
		queue_cmd(MODE_EXTRACT, 32'h0, 32'h0, 6'd0);
		queue_cmd(MODE_REMOVE, 32'h0, 32'h0, 6'd0);
		queue_cmd(MODE_EXTRACT, 32'h0, 32'h0, 6'd0);
		queue_cmd(MODE_EXTRACT, 32'h0, 32'h0, 6'd0);
		queue_cmd(MODE_EXTRACT, 32'h0, 32'h0, 6'd0);
		// random: alternate filling and draining phases
		fill_bias = 85;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 120 == 0)
				fill_bias = (fill_bias > 50) ? 25 : 85;
			if ($urandom_range(0, 99) < 5)
				m = MODE_QUERY;
			else if ($urandom_range(0, 99) < fill_bias)
				m = MODE_INSERT;
			else
				m = ($urandom_range(0, 1) == 0) ? MODE_EXTRACT : MODE_REMOVE;
			if (heap_cnt > 0 && $urandom_range(0, 3) != 0)
				p = 6'($urandom_range(0, heap_cnt - 1));
			else
				p = 6'($urandom);
			queue_cmd(m, pick_key(), $urandom, p);
		end
		total_cmds = pending_cmds.size();
	end

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd.valid <= 1'b0;
			cmd.data <= '0;
			cmd_gap = 0;
			sent_cmds = 0;
		end else if (!cmd.valid || cmd.ready) begin
			if (cmd.valid)
				sent_cmds++;
			if (cmd_gap > 0) begin
				cmd_gap--;
				cmd.valid <= 1'b0;
			end else if (pending_cmds.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
				cmd_gap = $urandom_range(1, 9) - 1;
				cmd.valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				cmd.data <= pending_cmds.pop_front();
				cmd.valid <= 1'b1;
			end else begin
				cmd.valid <= 1'b0;
			end
		end
	end

	// long result hold-off so the input side backs up
	initial begin
		hold_off = 1'b0;
		wait (sent_cmds >= 300);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// result monitor and checker
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			res.ready <= 1'b0;
			res_gap = 0;
			checked_res = 0;
			mismatches = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_res.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected result beat at %0t", $realtime);
				end else begin
					want = expected_res.pop_front();
					if (res.data.taken_key !== want.taken_key
							|| res.data.taken_payload !== want.taken_payload
							|| res.data.top_key !== want.top_key
							|| res.data.top_payload !== want.top_payload
							|| res.data.count !== want.count
							|| res.data.is_empty !== want.is_empty
							|| res.data.status !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: result %0d exp tk=%0d tp=%h top=%0d/%h n=%0d e=%0d st=%0d got tk=%0d tp=%h top=%0d/%h n=%0d e=%0d st=%0d",
								checked_res, want.taken_key, want.taken_payload,
								want.top_key, want.top_payload, want.count,
								want.is_empty, want.status, res.data.taken_key,
								res.data.taken_payload, res.data.top_key,
								res.data.top_payload, res.data.count,
								res.data.is_empty, res.data.status);
					end
				end
				checked_res++;
			end
			if (hold_off) begin
				res.ready <= 1'b0;
			end else if (res_gap > 0) begin
				res_gap--;
				res.ready <= 1'b0;
			end else if (pending_cmds.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
				res_gap = $urandom_range(1, 9) - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	initial begin
		wait (arst_n === 1'b1 && total_cmds > 0);
		wait (sent_cmds == total_cmds && expected_res.size() == 0);
		repeat (100) @(posedge clk);
		$display("Ran %0d commands, %0d results checked, heap peaked at %0d entries.",
			total_cmds, checked_res, max_fill);
		$display("Status counts: ok %0d, full %0d, empty %0d, bad position %0d.",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
			status_seen[ST_BAD_POS]);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end
endmodule
